// ----- hdl/ssp_pkg.sv -----
// shared types and constants for the shortest path engine
// no dependencies
`default_nettype none
package ssp_pkg;

  localparam int VERTEX_W        = 6;
  localparam int COUNT_W         = 7;
  localparam int DIST_W          = 22;
  localparam int WEIGHT_IN_W     = 16;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [DIST_W-1:0]  DIST_MAX            = 22'h3FFFFF;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET  = 7'd64;
  localparam logic [2:0]         REG_VERTEX_COUNT    = 3'd0;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_EREAD,
    S_EDATA,
    S_ECMP,
    S_OREAD,
    S_OWAIT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/single_source_shortest_paths.sv -----
// shortest path engine top level: edge store, distance memory and sequencer
// depends on ssp_pkg
//
// channel   direction  handshake                 payload
// input     in         start high, busy low      action, edge_from, edge_to,
//                                                edge_weight, source_vertex
// result    out        result_valid, one cycle   vertex, distance, reachable,
//                                                bad_source, edges_dropped, last
// config    in/out     apb psel/penable/pready   vertex_count at address 0
//
// load, clear and unknown beats never raise busy
// a bad source gives its single result the cycle after the beat, no busy
// a run scans for the minimum once per settled vertex plus a final empty scan,
// then, when the store is not empty, walks every stored edge for each settled
// vertex, then gives one result per vertex; all distance reads share one port
// reset is synchronous and active high; no clearing pass, the edge store
// needs none since only written entries are ever read
// the receiver cannot stall results: each beat is shown for one cycle
`default_nettype none
module single_source_shortest_paths
  import ssp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire  [1:0]             action,
  input  wire  [VERTEX_W-1:0]    edge_from,
  input  wire  [VERTEX_W-1:0]    edge_to,
  input  wire  [WEIGHT_IN_W-1:0] edge_weight,
  input  wire  [VERTEX_W-1:0]    source_vertex,
  output logic                   result_valid,
  output logic [VERTEX_W-1:0]    vertex,
  output logic [DIST_W-1:0]      distance,
  output logic                   reachable,
  output logic                   bad_source,
  output logic                   edges_dropped,
  output logic                   last,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [2:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int VB     = $clog2(MAX_VERTICES);
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W = 2 * VERTEX_W + WEIGHT_BITS;
  localparam int SUM_W  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  // configuration
  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] n_live;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;
  assign n_live = (vertex_count > COUNT_W'(MAX_VERTICES)) ?
                  COUNT_W'(MAX_VERTICES) : vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  // control state
  state_t state, state_next;
  logic   accept;
  logic   run_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign run_ok = ({1'b0, source_vertex} < n_live);

  logic [ECW-1:0]          edge_total;
  logic                    overflow;
  logic [MAX_VERTICES-1:0] found;
  logic [MAX_VERTICES-1:0] settled;

  // scan for minimum, one vertex read per cycle
  logic [COUNT_W-1:0] scan_idx;
  logic               pend;
  logic [VB-1:0]      pend_idx;
  logic               have_best;
  logic [VB-1:0]      best;
  logic [DIST_W-1:0]  best_dist;
  logic               better;

  // relaxation
  logic [ECW-1:0]      edge_idx;
  logic [EDGE_W-1:0]   edge_rd;
  logic [VERTEX_W-1:0] e_tail;
  logic [VERTEX_W-1:0] e_head;
  logic [WEIGHT_BITS-1:0] e_weight;
  logic                e_ok;
  logic [SUM_W-1:0]    sum;
  logic [DIST_W-1:0]   cand;
  logic [DIST_W-1:0]   cand_reg;
  logic [VB-1:0]       cur_h;

  // output walk
  logic [COUNT_W-1:0] out_idx;

  // memories
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
  logic [DIST_W-1:0] dist_rd;

  logic              dist_we;
  logic [VB-1:0]     dist_wa;
  logic [DIST_W-1:0] dist_wd;
  logic              dist_re;
  logic [VB-1:0]     dist_ra;
  logic              edge_we;
  logic              edge_re;
  logic [31:0]       w_wide;

  assign w_wide = 32'(edge_weight);

  assign {e_tail, e_head, e_weight} = edge_rd;
  assign e_ok = (e_tail == VERTEX_W'(best)) && ({1'b0, e_head} < n_live) &&
                !settled[e_head[VB-1:0]];
  assign sum  = SUM_W'(best_dist) + SUM_W'(e_weight);
  // saturate the path length
  assign cand = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

  assign better = found[pend_idx] && !settled[pend_idx] &&
                  (!have_best || dist_rd < best_dist);

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_total[EAW-1:0]] <= {edge_from, edge_to, w_wide[WEIGHT_BITS-1:0]};
    end
    if (edge_re) begin
      edge_rd <= edge_mem[edge_idx[EAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (dist_re) begin
      dist_rd <= dist_mem[dist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and memory strobes
  always_comb begin
    state_next = state;
    dist_we    = 1'b0;
    dist_wa    = cur_h;
    dist_wd    = cand_reg;
    dist_re    = 1'b0;
    dist_ra    = scan_idx[VB-1:0];
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && action == ACT_LOAD && edge_total != ECW'(MAX_EDGES)) begin
          edge_we = 1'b1;
        end
        if (accept && action == ACT_RUN && run_ok) begin
          dist_we    = 1'b1;
          dist_wa    = source_vertex[VB-1:0];
          dist_wd    = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx != n_live) begin
          dist_re = 1'b1;
        end else if (!pend) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (!have_best) begin
          state_next = S_OREAD;
        end else if (edge_total == '0) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_EREAD;
        end
      end
      S_EREAD: begin
        if (edge_idx == edge_total) begin
          state_next = S_SCAN;
        end else begin
          edge_re    = 1'b1;
          state_next = S_EDATA;
        end
      end
      S_EDATA: begin
        if (e_ok) begin
          dist_re    = 1'b1;
          dist_ra    = e_head[VB-1:0];
          state_next = S_ECMP;
        end else begin
          state_next = S_EREAD;
        end
      end
      S_ECMP: begin
        if (!found[cur_h] || dist_rd > cand_reg) begin
          dist_we = 1'b1;
        end
        state_next = S_EREAD;
      end
      S_OREAD: begin
        dist_re    = 1'b1;
        dist_ra    = out_idx[VB-1:0];
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        state_next = (out_idx + COUNT_W'(1) == n_live) ? S_IDLE : S_OREAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // edge count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end else if (accept && action == ACT_LOAD) begin
      if (edge_total != ECW'(MAX_EDGES)) begin
        edge_total <= edge_total + ECW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end else if (accept && action == ACT_CLEAR) begin
      edge_total <= '0;
      overflow   <= 1'b0;
    end
  end

  // run datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == S_SCAN) && (scan_idx != n_live);
    end
    pend_idx <= scan_idx[VB-1:0];
    if (state == S_SCAN && scan_idx != n_live) begin
      scan_idx <= scan_idx + COUNT_W'(1);
    end
    if (pend && better) begin
      have_best <= 1'b1;
      best      <= pend_idx;
      best_dist <= dist_rd;
    end
    unique case (state)
      S_IDLE: begin
        // only the source starts out reached
        found     <= MAX_VERTICES'(1) << source_vertex[VB-1:0];
        settled   <= '0;
        scan_idx  <= '0;
        have_best <= 1'b0;
        out_idx   <= '0;
      end
      S_PICK: begin
        if (have_best) begin
          settled[best] <= 1'b1;
        end
        edge_idx  <= '0;
        scan_idx  <= '0;
        have_best <= have_best && (edge_total != '0);
      end
      S_EREAD: begin
        if (edge_idx != edge_total) begin
          edge_idx <= edge_idx + ECW'(1);
        end else begin
          scan_idx  <= '0;
          have_best <= 1'b0;
        end
      end
      S_EDATA: begin
        cur_h    <= e_head[VB-1:0];
        cand_reg <= cand;
      end
      S_ECMP: begin
        if (!found[cur_h] || dist_rd > cand_reg) begin
          found[cur_h] <= 1'b1;
        end
      end
      S_OWAIT: begin
        out_idx <= out_idx + COUNT_W'(1);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OWAIT) ||
                      (accept && action == ACT_RUN && !run_ok);
    end
    if (accept && action == ACT_RUN && !run_ok) begin
      vertex        <= source_vertex;
      distance      <= '0;
      reachable     <= 1'b0;
      bad_source    <= 1'b1;
      edges_dropped <= overflow;
      last          <= 1'b1;
    end else if (state == S_OWAIT) begin
      vertex        <= out_idx[VERTEX_W-1:0];
      distance      <= settled[out_idx[VB-1:0]] ? dist_rd : '0;
      reachable     <= settled[out_idx[VB-1:0]];
      bad_source    <= 1'b0;
      edges_dropped <= overflow;
      last          <= (out_idx + COUNT_W'(1) == n_live);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ssp_checker.sv -----
// port-level checks on the shortest path engine, bound to the top level
// no package dependencies
`default_nettype none
module ssp_port_checks (
  input wire clk,
  input wire rst,
  input wire busy,
  input wire result_valid,
  input wire reachable,
  input wire bad_source,
  input wire last
);

  // an error beat is always marked as the last beat
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_source |-> last)
    else $error("bad source beat not marked last");

  // results outside a run are only the closing beat
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !busy |-> last)
    else $error("result beat while idle that is not last");

  // result beats of a run are spaced by the memory read
  a_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> !result_valid)
    else $error("back to back result beats");

  // a run never opens with a result pending
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !result_valid)
    else $error("result beat at run start");

  a_reach: assert property (@(posedge clk) disable iff (rst)
    result_valid && reachable |-> !bad_source)
    else $error("error beat marked reachable");

endmodule

bind single_source_shortest_paths ssp_port_checks u_ssp_port_checks (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .reachable    (reachable),
  .bad_source   (bad_source),
  .last         (last)
);
`default_nettype wire
